// ===== sv/mhd_pkg.sv =====
// ----------------------------------------------------------------------------
// Modified Hausdorff distance package
// Shared types, sizes and codes of the distance engine.
// ----------------------------------------------------------------------------
package mhd_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int MAX_DIM     = 4;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int DSQ_W       = SQ_W + 2;
  localparam int ROOT_W      = DSQ_W / 2 + 9;
  localparam int SUM_W       = ROOT_W + IDX_W + 1;
  localparam int DIST_W      = 27;
  localparam int POINT_W     = MAX_DIM * COORD_WIDTH;
  localparam int DIM_W       = 3;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_LOAD_A  = 2'd0;
  localparam opcode_t OP_LOAD_B  = 2'd1;
  localparam opcode_t OP_COMPUTE = 2'd2;
  localparam opcode_t OP_CLEAR   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ACC, S_NEXTJ, S_ROOT, S_DIV, S_DIR, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [DSQ_W-1:0] value;
  } root_req_t;

endpackage

// ===== sv/mhd_root.sv =====
// ----------------------------------------------------------------------------
// Integer square root
// Bit-serial root of d * 65536, one result bit per cycle.
// ----------------------------------------------------------------------------
module mhd_root
  import mhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  root_req_t         req,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [RAD_W+1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RAD_W+1:0]  shifted;
  logic [RAD_W+1:0]  trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[RAD_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial    = {{(RAD_W + 2 - ROOT_W - 2){1'b0}}, root_r, 2'b01};
    if (req.start) begin
      rad_nxt  = {{(RAD_W - DSQ_W - 16){1'b0}}, req.value, 16'd0};
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = STEP_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== sv/mhd_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Divides the root sum by the point count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mhd_div
  import mhd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/modified_hausdorff_distance.sv =====
// ----------------------------------------------------------------------------
// Modified Hausdorff distance engine
// Loads points into two set memories and computes the modified Hausdorff
// distance between them on request.
// ----------------------------------------------------------------------------
// Channel  Ports        Content
// in       in_t*        tdata: opcode, coord_0..coord_3 (66 bits in 72)
// out      out_t*       tdata: distance, status (29 bits in 32)
// cfg      cfg_*        dimensions, 3 bits
//
// Load and clear beats go from idle straight to the output state. A compute
// beat walks every pair of points, each pair through memory read, coordinate
// squares and sum, plus a root per source point, a division and a direction
// switch state after each direction. Reset is synchronous and empties both
// sets. The result waits in an output register; a stalled output holds the
// engine but not configuration.
// ----------------------------------------------------------------------------
module modified_hausdorff_distance
  import mhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode, coord_0, coord_1, coord_2, coord_3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance, status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  logic [POINT_W-1:0] mem_a [MAX_POINTS];
  logic [POINT_W-1:0] mem_b [MAX_POINTS];
  logic [POINT_W-1:0] rd_a_r, rd_b_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [DIM_W-1:0]  dim_cfg_r, dim_r, dim_nxt;
  logic              dir_r, dir_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [DSQ_W-1:0]  best_r, best_nxt;
  logic              have_r, have_nxt;
  logic [SQ_W-1:0]   sq_r [MAX_DIM];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIST_W-1:0] ab_r, ab_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  status_t           stat_r, stat_nxt;

  opcode_t           op;
  logic [CNT_W-1:0]  ns, nd;
  logic [POINT_W-1:0] src_pt, dst_pt;
  logic signed [DIFF_W-1:0] diff [MAX_DIM];
  logic [DSQ_W-1:0]  dsum;
  logic              root_done, div_done, div_start;
  logic [ROOT_W-1:0] root_val;
  logic [SUM_W-1:0]  quo;
  logic [DIST_W-1:0] mean;
  root_req_t         rreq;
  logic              wr_a, wr_b;
  logic [IDX_W-1:0]  rd_a_idx, rd_b_idx;

  assign op = opcode_t'(in_tdata[1:0]);
  assign ns = dir_r ? cnt_b_r : cnt_a_r;
  assign nd = dir_r ? cnt_a_r : cnt_b_r;
  assign src_pt = dir_r ? rd_b_r : rd_a_r;
  assign dst_pt = dir_r ? rd_a_r : rd_b_r;

  always_comb begin
    for (int k = 0; k < MAX_DIM; k++) begin
      diff[k] = $signed({src_pt[k*COORD_WIDTH+COORD_WIDTH-1],
                         src_pt[k*COORD_WIDTH +: COORD_WIDTH]})
              - $signed({dst_pt[k*COORD_WIDTH+COORD_WIDTH-1],
                         dst_pt[k*COORD_WIDTH +: COORD_WIDTH]});
    end
  end

  always_comb begin
    dsum = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      if (DIM_W'(k) < dim_r) dsum = dsum + DSQ_W'(sq_r[k]);
    end
  end

  assign mean = (quo > SUM_W'(2 ** DIST_W - 1)) ? '1 : quo[DIST_W-1:0];

  always_comb begin
    rd_a_idx = dir_r ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
    rd_b_idx = dir_r ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (op == OP_COMPUTE && cnt_a_r != '0 && cnt_b_r != '0) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_NEXTJ;
      S_NEXTJ: state_nxt = (j_r + 1'b1 == nd) ? S_ROOT : S_RD;
      S_ROOT: begin
        if (root_done) state_nxt = (i_r + 1'b1 == ns) ? S_DIV : S_RD;
      end
      S_DIV:   if (div_done) state_nxt = S_DIR;
      S_DIR:   state_nxt = dir_r ? S_OUT : S_RD;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    dim_nxt = dim_r;
    dir_nxt = dir_r;
    i_nxt = i_r;
    j_nxt = j_r;
    best_nxt = best_r;
    have_nxt = have_r;
    sum_nxt = sum_r;
    ab_nxt = ab_r;
    dist_nxt = dist_r;
    stat_nxt = stat_r;
    wr_a = 1'b0;
    wr_b = 1'b0;
    rreq.start = 1'b0;
    rreq.value = best_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dist_nxt = '0;
          stat_nxt = ST_OK;
          dir_nxt = 1'b0;
          i_nxt = '0;
          j_nxt = '0;
          have_nxt = 1'b0;
          sum_nxt = '0;
          dim_nxt = (dim_cfg_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_cfg_r;
          case (op)
            OP_LOAD_A: begin
              if (cnt_a_r >= CNT_W'(MAX_POINTS)) stat_nxt = ST_FULL;
              else begin
                wr_a = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (cnt_b_r >= CNT_W'(MAX_POINTS)) stat_nxt = ST_FULL;
              else begin
                wr_b = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end
            OP_COMPUTE: begin
              if (cnt_a_r == '0 || cnt_b_r == '0) stat_nxt = ST_EMPTY;
            end
            default: begin
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
            end
          endcase
        end
      end
      S_NEXTJ: begin
        if (!have_r || dsum < best_r) best_nxt = dsum;
        have_nxt = 1'b1;
        if (j_r + 1'b1 == nd) begin
          rreq.start = 1'b1;
          rreq.value = (!have_r || dsum < best_r) ? dsum : best_r;
          j_nxt = '0;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          sum_nxt = sum_r + SUM_W'(root_val);
          have_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 == ns) div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!dir_r) ab_nxt = mean;
          else dist_nxt = (ab_r > mean) ? ab_r : mean;
        end
      end
      S_DIR: begin
        dir_nxt = 1'b1;
        i_nxt = '0;
        j_nxt = '0;
        sum_nxt = '0;
        have_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a_r[IDX_W-1:0]] <= in_tdata[2 +: POINT_W];
    if (wr_b) mem_b[cnt_b_r[IDX_W-1:0]] <= in_tdata[2 +: POINT_W];
    rd_a_r <= mem_a[rd_a_idx];
    rd_b_r <= mem_b[rd_b_idx];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_DIM; k++) begin
      sq_r[k] <= SQ_W'(diff[k] * diff[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      dim_cfg_r <= DIM_W'(2);
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      if (cfg_we) dim_cfg_r <= cfg_wdata;
    end
    dim_r <= dim_nxt;
    dir_r <= dir_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    best_r <= best_nxt;
    have_r <= have_nxt;
    sum_r <= sum_nxt;
    ab_r <= ab_nxt;
    dist_r <= dist_nxt;
    stat_r <= stat_nxt;
  end

  mhd_root u_root (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rreq),
    .done (root_done),
    .root (root_val)
  );

  mhd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_r + SUM_W'(root_val)),
    .divisor (ns),
    .done    (div_done),
    .quotient(quo)
  );

  assign out_tdata = {3'b000, stat_r, dist_r};

endmodule
